>>> rtl/can_frame_table_bit_eval_assert.svh
// assertion macros for the can frame table checker
`ifndef CAN_FRAME_TABLE_BIT_EVAL_ASSERT_SVH
`define CAN_FRAME_TABLE_BIT_EVAL_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CFTBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CFTBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cftbe_pkg.sv
// shared types and constants for the can frame table
package cftbe_pkg;

    localparam int ID_W      = 29;
    localparam int DATA_W    = 64;
    localparam int BIT_W     = 6;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 2;
    localparam int NUM_TERMS = 3;

    localparam logic [COUNT_W-1:0] MAX_TERMS = 2'd3;

    typedef enum logic
    {
        REQ_STORE = 1'b0,
        REQ_EVAL  = 1'b1
    } req_type_t;

    typedef enum logic [MODE_W-1:0]
    {
        MODE_SINGLE = 2'd0,
        MODE_AND    = 2'd1,
        MODE_OR     = 2'd2
    } combine_mode_t;

endpackage

>>> rtl/cftbe_term_read.sv
// reads one payload bit of a frame by identifier across all table slots
module cftbe_term_read #(
    parameter int SLOTS = 16
) (
    input  logic [SLOTS-1:0]               slot_valid,
    input  logic [cftbe_pkg::ID_W-1:0]     slot_ident   [SLOTS],
    input  logic [cftbe_pkg::DATA_W-1:0]   slot_payload [SLOTS],
    input  logic [cftbe_pkg::ID_W-1:0]     term_id,
    input  logic [cftbe_pkg::BIT_W-1:0]    term_bit,
    output logic                           term_value
);

    logic [SLOTS-1:0] match;
    logic [SLOTS-1:0] slot_bit;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i]    = slot_valid[i] && (slot_ident[i] == term_id);
            slot_bit[i] = slot_payload[i][term_bit];
        end
    end

    // identifiers are unique among valid slots, so at most one match
    assign term_value = |(match & slot_bit);

endmodule

>>> rtl/can_frame_table_bit_eval.sv
// can frame table with bit-term evaluation, top level
//
// one input channel (in_valid/in_ready) carries either a store request,
// which writes frame_data under frame_id into the table, or an evaluate
// request, which reads up to three (identifier, bit) terms and combines
// them as single, and or or. every request gives exactly one result on
// the output channel (out_valid/out_ready): eval_result for evaluates,
// store_accepted or store_dropped for stores.
// a request is held in an input register, checked against all slots in
// parallel, and its result moves from there into the output register;
// throughput is one request per cycle while the receiver does not stall.
// that rate is set by the parallel identifier compare over TABLE_SLOTS.
// the table is updated as a store moves to the output register, so the
// very next request already sees it.
// reset empties the table and both pipeline registers at once.
// when the receiver stalls the result is held; one more request is taken
// into the input register and in_ready then drops until the output moves.
module can_frame_table_bit_eval #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [cftbe_pkg::ID_W-1:0]        frame_id,
    input  logic [cftbe_pkg::DATA_W-1:0]      frame_data,
    input  logic [cftbe_pkg::MODE_W-1:0]      combine_mode,
    input  logic [cftbe_pkg::COUNT_W-1:0]     term_count,
    input  logic [cftbe_pkg::ID_W-1:0]        term0_id,
    input  logic [cftbe_pkg::BIT_W-1:0]       term0_bit,
    input  logic [cftbe_pkg::ID_W-1:0]        term1_id,
    input  logic [cftbe_pkg::BIT_W-1:0]       term1_bit,
    input  logic [cftbe_pkg::ID_W-1:0]        term2_id,
    input  logic [cftbe_pkg::BIT_W-1:0]       term2_bit,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              eval_result,
    output logic                              store_accepted,
    output logic                              store_dropped
);

    localparam int NT = cftbe_pkg::NUM_TERMS;

    logic [TABLE_SLOTS-1:0]             slot_valid_reg;
    logic [TABLE_SLOTS-1:0]             slot_valid_next;
    logic [cftbe_pkg::ID_W-1:0]         slot_ident_reg   [TABLE_SLOTS];
    logic [cftbe_pkg::DATA_W-1:0]       slot_payload_reg [TABLE_SLOTS];

    logic                               s1_valid_reg;
    cftbe_pkg::req_type_t               s1_req_reg;
    logic [cftbe_pkg::ID_W-1:0]         s1_frame_id_reg;
    logic [cftbe_pkg::DATA_W-1:0]       s1_frame_data_reg;
    logic [cftbe_pkg::MODE_W-1:0]       s1_mode_reg;
    logic [cftbe_pkg::COUNT_W-1:0]      s1_count_reg;
    logic [cftbe_pkg::ID_W-1:0]         s1_term_id_reg  [NT];
    logic [cftbe_pkg::BIT_W-1:0]        s1_term_bit_reg [NT];

    logic                               out_valid_reg;
    logic                               eval_result_reg;
    logic                               store_accepted_reg;
    logic                               store_dropped_reg;

    logic                               in_fire;
    logic                               s1_advance;

    logic [TABLE_SLOTS-1:0]             store_match;
    logic [TABLE_SLOTS-1:0]             slot_free;
    logic [TABLE_SLOTS-1:0]             first_free;
    logic [TABLE_SLOTS-1:0]             slot_write;
    logic                               store_hit;
    logic                               store_ok;
    logic                               do_store;

    logic [NT-1:0]                      term_value;
    logic [NT-1:0]                      term_used;
    logic [cftbe_pkg::COUNT_W-1:0]      count_eff;
    logic                               eval_next;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg         <= cftbe_pkg::req_type_t'(req_type);
            s1_frame_id_reg    <= frame_id;
            s1_frame_data_reg  <= frame_data;
            s1_mode_reg        <= combine_mode;
            s1_count_reg       <= term_count;
            s1_term_id_reg[0]  <= term0_id;
            s1_term_bit_reg[0] <= term0_bit;
            s1_term_id_reg[1]  <= term1_id;
            s1_term_bit_reg[1] <= term1_bit;
            s1_term_id_reg[2]  <= term2_id;
            s1_term_bit_reg[2] <= term2_bit;
        end
    end

    // store path: update a matching slot, else claim the lowest free one
    always_comb
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            store_match[i] = slot_valid_reg[i] && (slot_ident_reg[i] == s1_frame_id_reg);
        end
    end

    assign slot_free  = ~slot_valid_reg;
    assign first_free = slot_free & (~slot_free + {{(TABLE_SLOTS-1){1'b0}}, 1'b1});
    assign store_hit  = |store_match;
    assign store_ok   = store_hit || (|slot_free);
    assign do_store   = s1_advance && (s1_req_reg == cftbe_pkg::REQ_STORE);
    assign slot_write = do_store ? (store_hit ? store_match : first_free)
                                 : {TABLE_SLOTS{1'b0}};

    assign slot_valid_next = slot_valid_reg | slot_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= {TABLE_SLOTS{1'b0}};
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (slot_write[i])
            begin
                slot_ident_reg[i]   <= s1_frame_id_reg;
                slot_payload_reg[i] <= s1_frame_data_reg;
            end
        end
    end

    // evaluate path
    for (genvar k = 0; k < NT; k++)
    begin : g_term
        cftbe_term_read #(
            .SLOTS (TABLE_SLOTS)
        ) u_term_read (
            .slot_valid   (slot_valid_reg),
            .slot_ident   (slot_ident_reg),
            .slot_payload (slot_payload_reg),
            .term_id      (s1_term_id_reg[k]),
            .term_bit     (s1_term_bit_reg[k]),
            .term_value   (term_value[k])
        );

        assign term_used[k] = cftbe_pkg::COUNT_W'(k) < count_eff;
    end

    assign count_eff = (s1_count_reg > cftbe_pkg::MAX_TERMS) ? cftbe_pkg::MAX_TERMS
                                                             : s1_count_reg;

    always_comb
    begin
        eval_next = 1'b0;
        if (count_eff != '0)
        begin
            unique case (s1_mode_reg)
                cftbe_pkg::MODE_SINGLE: eval_next = term_value[0];
                cftbe_pkg::MODE_AND:    eval_next = &(term_value | ~term_used);
                cftbe_pkg::MODE_OR:     eval_next = |(term_value & term_used);
                default:                eval_next = 1'b0;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            if (s1_req_reg == cftbe_pkg::REQ_STORE)
            begin
                eval_result_reg    <= 1'b0;
                store_accepted_reg <= store_ok;
                store_dropped_reg  <= !store_ok;
            end
            else
            begin
                eval_result_reg    <= eval_next;
                store_accepted_reg <= 1'b0;
                store_dropped_reg  <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign eval_result    = eval_result_reg;
    assign store_accepted = store_accepted_reg;
    assign store_dropped  = store_dropped_reg;

endmodule

>>> rtl/cftbe_checker.sv
// port-level checker for the can frame table, bound to the top level
`include "can_frame_table_bit_eval_assert.svh"

module cftbe_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic eval_result,
    input logic store_accepted,
    input logic store_dropped
);

    `CFTBE_ASSERT_NOW(a_one_store_flag, clk, rst_n, out_valid, !(store_accepted && store_dropped), "store result flags both accepted and dropped")
    `CFTBE_ASSERT_NOW(a_eval_no_flags, clk, rst_n, out_valid && eval_result, !store_accepted && !store_dropped, "evaluate result carries store flags")
    `CFTBE_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "request refused with an empty output register")
    `CFTBE_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(eval_result) && $stable(store_accepted) && $stable(store_dropped), "stalled result changed")

endmodule

bind can_frame_table_bit_eval cftbe_checker u_cftbe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .eval_result    (eval_result),
    .store_accepted (store_accepted),
    .store_dropped  (store_dropped)
);

>>> dv/can_frame_table_bit_eval_test.sv
// self-checking testbench for the can frame table with bit-term evaluation
module can_frame_table_bit_eval_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W      = cftbe_pkg::ID_W;
    localparam int DATA_W    = cftbe_pkg::DATA_W;
    localparam int BIT_W     = cftbe_pkg::BIT_W;
    localparam int MODE_W    = cftbe_pkg::MODE_W;
    localparam int COUNT_W   = cftbe_pkg::COUNT_W;
    localparam int NUM_TERMS = cftbe_pkg::NUM_TERMS;
    localparam logic [COUNT_W-1:0] MAX_TERMS = cftbe_pkg::MAX_TERMS;

    localparam int SLOTS = 16;
    localparam logic [ID_W-1:0] ID_MIN = '0;
    localparam logic [ID_W-1:0] ID_MAX = '1;
    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

    typedef struct {
        cftbe_pkg::req_type_t   kind;
        logic [ID_W-1:0]        id;
        logic [DATA_W-1:0]      data;
        logic [MODE_W-1:0]      mode;
        logic [COUNT_W-1:0]     count;
        logic [ID_W-1:0]        tid0;
        logic [BIT_W-1:0]       tbit0;
        logic [ID_W-1:0]        tid1;
        logic [BIT_W-1:0]       tbit1;
        logic [ID_W-1:0]        tid2;
        logic [BIT_W-1:0]       tbit2;
    } can_req_t;

    typedef struct {
        logic result;
        logic accepted;
        logic dropped;
    } outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                req_type = 1'b0;
    logic [ID_W-1:0]     frame_id = '0;
    logic [DATA_W-1:0]   frame_data = '0;
    logic [MODE_W-1:0]   combine_mode = '0;
    logic [COUNT_W-1:0]  term_count = '0;
    logic [ID_W-1:0]     term0_id = '0;
    logic [BIT_W-1:0]    term0_bit = '0;
    logic [ID_W-1:0]     term1_id = '0;
    logic [BIT_W-1:0]    term1_bit = '0;
    logic [ID_W-1:0]     term2_id = '0;
    logic [BIT_W-1:0]    term2_bit = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                eval_result;
    logic                store_accepted;
    logic                store_dropped;

    logic                tbl_used [SLOTS];
    logic [ID_W-1:0]     tbl_id   [SLOTS];
    logic [DATA_W-1:0]   tbl_data [SLOTS];

    outcome_t            outcome_q [$];
    int                  snd_idle_pct = 0;
    int                  rcv_idle_pct = 0;
    int                  mismatches = 0;
    int                  n_stores = 0;
    int                  n_dropped = 0;
    int                  n_evals = 0;
    int                  n_checked = 0;

    can_frame_table_bit_eval #(.TABLE_SLOTS(SLOTS)) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .frame_id       (frame_id),
        .frame_data     (frame_data),
        .combine_mode   (combine_mode),
        .term_count     (term_count),
        .term0_id       (term0_id),
        .term0_bit      (term0_bit),
        .term1_id       (term1_id),
        .term1_bit      (term1_bit),
        .term2_id       (term2_id),
        .term2_bit      (term2_bit),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .eval_result    (eval_result),
        .store_accepted (store_accepted),
        .store_dropped  (store_dropped)
    );

    always #2 clk = ~clk;

    // frame table predictor
    function automatic int find_slot(logic [ID_W-1:0] id);
        for (int s = 0; s < SLOTS; s++)
        begin
            if (tbl_used[s] && tbl_id[s] == id)
                return s;
        end
        return -1;
    endfunction

    function automatic logic frame_bit(logic [ID_W-1:0] id, logic [BIT_W-1:0] b);
        int s;
        s = find_slot(id);
        if (s < 0)
            return 1'b0;
        return tbl_data[s][b];
    endfunction

    function automatic logic write_frame(logic [ID_W-1:0] id, logic [DATA_W-1:0] data);
        int s;
        s = find_slot(id);
        if (s >= 0)
        begin
            tbl_data[s] = data;
            return 1'b1;
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            if (!tbl_used[k])
            begin
                tbl_used[k] = 1'b1;
                tbl_id[k]   = id;
                tbl_data[k] = data;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int used_slots();
        int n;
        n = 0;
        for (int s = 0; s < SLOTS; s++)
            n += tbl_used[s];
        return n;
    endfunction

    function automatic outcome_t apply_request(can_req_t r);
        outcome_t o;
        logic [ID_W-1:0] ids [NUM_TERMS];
        logic [BIT_W-1:0] bits [NUM_TERMS];
        int n;
        o = '{1'b0, 1'b0, 1'b0};
        if (r.kind == cftbe_pkg::REQ_STORE)
        begin
            o.accepted = write_frame(r.id, r.data);
            o.dropped  = !o.accepted;
            return o;
        end
        ids[0] = r.tid0;  bits[0] = r.tbit0;
        ids[1] = r.tid1;  bits[1] = r.tbit1;
        ids[2] = r.tid2;  bits[2] = r.tbit2;
        n = (r.count > MAX_TERMS) ? int'(MAX_TERMS) : int'(r.count);
        if (n == 0)
            return o;
        case (r.mode)
            cftbe_pkg::MODE_SINGLE: o.result = frame_bit(ids[0], bits[0]);
            cftbe_pkg::MODE_AND:
            begin
                o.result = 1'b1;
                for (int k = 0; k < n; k++)
                    o.result &= frame_bit(ids[k], bits[k]);
            end
            cftbe_pkg::MODE_OR:
            begin
                for (int k = 0; k < n; k++)
                    o.result |= frame_bit(ids[k], bits[k]);
            end
            default: o.result = 1'b0;
        endcase
        return o;
    endfunction

    // request builders
    function automatic logic [ID_W-1:0] any_id();
        return ID_W'($urandom);
    endfunction

    function automatic logic [DATA_W-1:0] any_data();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        do
            id = any_id();
        while (find_slot(id) >= 0);
        return id;
    endfunction

    function automatic logic [ID_W-1:0] known_id();
        int s;
        if (used_slots() == 0)
            return any_id();
        do
            s = $urandom_range(SLOTS - 1);
        while (!tbl_used[s]);
        return tbl_id[s];
    endfunction

    function automatic can_req_t store_req(logic [ID_W-1:0] id, logic [DATA_W-1:0] data);
        can_req_t r;
        r.kind  = cftbe_pkg::REQ_STORE;
        r.id    = id;
        r.data  = data;
        r.mode  = MODE_W'($urandom);
        r.count = COUNT_W'($urandom);
        r.tid0  = any_id();
        r.tbit0 = BIT_W'($urandom);
        r.tid1  = any_id();
        r.tbit1 = BIT_W'($urandom);
        r.tid2  = any_id();
        r.tbit2 = BIT_W'($urandom);
        return r;
    endfunction

    function automatic can_req_t eval_req(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count,
                                          logic [ID_W-1:0] i0, logic [BIT_W-1:0] b0,
                                          logic [ID_W-1:0] i1, logic [BIT_W-1:0] b1,
                                          logic [ID_W-1:0] i2, logic [BIT_W-1:0] b2);
        can_req_t r;
        r.kind  = cftbe_pkg::REQ_EVAL;
        r.id    = any_id();
        r.data  = any_data();
        r.mode  = mode;
        r.count = count;
        r.tid0  = i0;
        r.tbit0 = b0;
        r.tid1  = i1;
        r.tbit1 = b1;
        r.tid2  = i2;
        r.tbit2 = b2;
        return r;
    endfunction

    function automatic logic [ID_W-1:0] term_id();
        return ($urandom_range(99) < 75) ? known_id() : any_id();
    endfunction

    function automatic can_req_t random_request();
        logic [ID_W-1:0] id;
        if ($urandom_range(99) < 40)
        begin
            id = ($urandom_range(99) < 60) ? known_id() : any_id();
            return store_req(id, any_data());
        end
        return eval_req(MODE_W'($urandom), COUNT_W'($urandom),
                        term_id(), BIT_W'($urandom), term_id(), BIT_W'($urandom),
                        term_id(), BIT_W'($urandom));
    endfunction

    // request driver
    task automatic send_request(input can_req_t r);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        req_type     = r.kind;
        frame_id     = r.id;
        frame_data   = r.data;
        combine_mode = r.mode;
        term_count   = r.count;
        term0_id     = r.tid0;
        term0_bit    = r.tbit0;
        term1_id     = r.tid1;
        term1_bit    = r.tbit1;
        term2_id     = r.tid2;
        term2_bit    = r.tbit2;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        outcome_q.push_back(apply_request(r));
        if (r.kind == cftbe_pkg::REQ_STORE)
        begin
            n_stores++;
            n_dropped += outcome_q[$].dropped;
        end
        else
            n_evals++;
    endtask

    always @(negedge clk)
        out_ready = ($urandom_range(99) >= rcv_idle_pct);

    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = outcome_q.pop_front();
                n_checked++;
                if (eval_result !== want.result)
                begin
                    $error("eval_result: expected %0b, got %0b", want.result, eval_result);
                    mismatches++;
                end
                if (store_accepted !== want.accepted)
                begin
                    $error("store_accepted: expected %0b, got %0b",
                           want.accepted, store_accepted);
                    mismatches++;
                end
                if (store_dropped !== want.dropped)
                begin
                    $error("store_dropped: expected %0b, got %0b",
                           want.dropped, store_dropped);
                    mismatches++;
                end
            end
        end
    end

    // test sequences
    task automatic test_empty_table();
        send_request(eval_req(cftbe_pkg::MODE_SINGLE, 2'd1,
                              ID_MIN, 6'd0, ID_MAX, 6'd63, ID_MIN, 6'd0));
        send_request(eval_req(cftbe_pkg::MODE_AND, 2'd3,
                              ID_MIN, 6'd0, ID_MAX, 6'd63, any_id(), 6'd31));
        send_request(eval_req(cftbe_pkg::MODE_OR, 2'd3,
                              ID_MAX, 6'd63, ID_MIN, 6'd0, any_id(), 6'd17));
    endtask

    task automatic test_store_and_read();
        send_request(store_req(ID_MIN, '1));
        send_request(store_req(ID_MAX, 64'h8000_0000_0000_0001));
        send_request(eval_req(cftbe_pkg::MODE_SINGLE, 2'd1,
                              ID_MIN, 6'd0, ID_MIN, 6'd0, ID_MIN, 6'd0));
        send_request(eval_req(cftbe_pkg::MODE_SINGLE, 2'd1,
                              ID_MAX, 6'd63, ID_MIN, 6'd0, ID_MIN, 6'd0));
        send_request(eval_req(cftbe_pkg::MODE_SINGLE, 2'd1,
                              ID_MAX, 6'd62, ID_MIN, 6'd0, ID_MIN, 6'd0));
        send_request(eval_req(cftbe_pkg::MODE_AND, 2'd3,
                              ID_MIN, 6'd5, ID_MAX, 6'd0, ID_MAX, 6'd63));
        send_request(eval_req(cftbe_pkg::MODE_AND, 2'd2,
                              ID_MIN, 6'd1, ID_MAX, 6'd1, ID_MIN, 6'd0));
        send_request(eval_req(cftbe_pkg::MODE_OR, 2'd3,
                              ID_MAX, 6'd30, fresh_id(), 6'd7, ID_MIN, 6'd40));
        send_request(eval_req(cftbe_pkg::MODE_OR, 2'd3,
                              ID_MAX, 6'd2, fresh_id(), 6'd9, ID_MAX, 6'd62));
    endtask

    task automatic test_special_cases();
        // zero terms, undefined mode, single ignores later terms, single on an unassigned id, or with one term
        send_request(eval_req(cftbe_pkg::MODE_AND, 2'd0,
                              ID_MIN, 6'd0, ID_MAX, 6'd0, ID_MIN, 6'd7));
        send_request(eval_req(MODE_UNDEF, 2'd3,
                              ID_MIN, 6'd0, ID_MAX, 6'd63, ID_MIN, 6'd8));
        send_request(eval_req(cftbe_pkg::MODE_SINGLE, 2'd3,
                              ID_MIN, 6'd3, fresh_id(), 6'd3, ID_MAX, 6'd1));
        send_request(eval_req(cftbe_pkg::MODE_SINGLE, 2'd2,
                              fresh_id(), 6'd0, ID_MIN, 6'd0, ID_MAX, 6'd63));
        send_request(eval_req(cftbe_pkg::MODE_OR, 2'd1,
                              ID_MAX, 6'd5, ID_MIN, 6'd5, ID_MAX, 6'd63));
    endtask

    task automatic test_update_existing();
        send_request(store_req(ID_MIN, '0));
        send_request(eval_req(cftbe_pkg::MODE_OR, 2'd2,
                              ID_MIN, 6'd0, ID_MIN, 6'd63, ID_MAX, 6'd0));
        send_request(store_req(ID_MAX, 64'h5555_5555_5555_5555));
        send_request(eval_req(cftbe_pkg::MODE_AND, 2'd3,
                              ID_MAX, 6'd0, ID_MAX, 6'd62, ID_MAX, 6'd2));
    endtask

    task automatic test_table_full();
        logic [ID_W-1:0] extra;
        while (used_slots() < SLOTS)
            send_request(store_req(fresh_id(), any_data()));
        extra = fresh_id();
        send_request(store_req(extra, '1));
        send_request(eval_req(cftbe_pkg::MODE_OR, 2'd1,
                              extra, 6'd0, extra, 6'd63, extra, 6'd31));
        send_request(store_req(known_id(), any_data()));
    endtask

    task automatic run_random(input int n);
        repeat (n)
            send_request(random_request());
    endtask

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            tbl_used[s] = 1'b0;
            tbl_id[s]   = '0;
            tbl_data[s] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        snd_idle_pct = 22;
        rcv_idle_pct = 83;
        test_empty_table();
        test_store_and_read();
        test_special_cases();
        test_update_existing();
        run_random(250);

        snd_idle_pct = 83;
        rcv_idle_pct = 22;
        test_table_full();
        run_random(250);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(250);

        @(negedge clk);
        in_valid = 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d requests: %0d stores (%0d dropped on a full table), %0d evaluates",
                 n_stores + n_evals, n_stores, n_dropped, n_evals);
        $display("%0d results checked under three sender/receiver stall patterns", n_checked);
        if (mismatches == 0)
            $display("PASS can_frame_table_bit_eval");
        else
            $display("FAIL can_frame_table_bit_eval");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("FAIL can_frame_table_bit_eval");
        $finish;
    end

endmodule
